// ===== rtl/ccrs_pkg.sv =====
package ccrs_pkg;

  localparam int SiteCount = 512;
  localparam int RotationIterations = 32;
  localparam int AtanLen = 40;
  localparam int IterCount = (RotationIterations < AtanLen) ? RotationIterations : AtanLen;
  localparam int AddrW = $clog2(SiteCount);
  localparam int IterW = (IterCount > 1) ? $clog2(IterCount) : 1;

  // Datapath width of the rotation unit: 8 guard bits plus growth headroom.
  localparam int RotW = 44;
  localparam int AngW = 34;
  localparam int GuardBits = 8;

  localparam logic [31:0] CordicGain = 32'h9B74EDA8;

  localparam logic [1:0] OpLoad   = 2'd0;
  localparam logic [1:0] OpSweep  = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic KindSweep = 1'b0;
  localparam logic KindRead  = 1'b1;

  localparam logic [39:0] GainReset   = 40'd8589934592;
  localparam logic [31:0] OffsetReset = 32'd1028592847;

  typedef struct packed {
    logic [1:0]         operation;
    logic [8:0]         site_index;
    logic signed [31:0] load_amplitude;
    logic [31:0]        load_phase;
  } cmd_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] amplitude_out;
    logic [31:0]        phase_out;
  } result_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turns(input logic [5:0] i);
    logic [29:0] v;
    unique case (i)
      6'd0:  v = 30'd536870912;
      6'd1:  v = 30'd316933406;
      6'd2:  v = 30'd167458907;
      6'd3:  v = 30'd85004756;
      6'd4:  v = 30'd42667331;
      6'd5:  v = 30'd21354465;
      6'd6:  v = 30'd10679838;
      6'd7:  v = 30'd5340245;
      6'd8:  v = 30'd2670163;
      6'd9:  v = 30'd1335087;
      6'd10: v = 30'd667544;
      6'd11: v = 30'd333772;
      6'd12: v = 30'd166886;
      6'd13: v = 30'd83443;
      6'd14: v = 30'd41722;
      6'd15: v = 30'd20861;
      6'd16: v = 30'd10430;
      6'd17: v = 30'd5215;
      6'd18: v = 30'd2608;
      6'd19: v = 30'd1304;
      6'd20: v = 30'd652;
      6'd21: v = 30'd326;
      6'd22: v = 30'd163;
      6'd23: v = 30'd81;
      6'd24: v = 30'd41;
      6'd25: v = 30'd20;
      6'd26: v = 30'd10;
      6'd27: v = 30'd5;
      6'd28: v = 30'd3;
      6'd29: v = 30'd1;
      6'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/chaotic_rotation_chain_sweep.sv =====
// Ring of sites, each holding a signed Q1.30 amplitude and a 32-bit phase
// (fraction of a turn). An item is taken when start is high and busy is low.
// A load writes one site in the accepting cycle and gives no result. A read
// gives one result (kind 1) after a registered read; reading a site that
// was never loaded since reset returns undefined data. A sweep steps every
// even site in rising order and then every odd site, rotating the pair
// (k, k+1 wrapping) by 2*pi*phase[k] and then remapping phase[k] to
// frac(gain*phase + offset); it ends with one result of kind 0 and zero data.
// Every site must be loaded before a sweep. A sweep holds busy while each
// site step runs through the one shared CORDIC stage once per iteration,
// plus a prescale multiply for each amplitude and the memory reads and
// writes of the site stores; the default has 512 sites and 32 iterations.
// The result strobe lasts exactly one cycle and cannot be held off, so the
// receiver must take every result in the cycle it appears. Configuration
// registers (gain at address 0, offset at address 8) must be written only
// while the block is idle; the block itself does not enforce this.
module chaotic_rotation_chain_sweep (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  ccrs_pkg::cmd_t          cmd_i,
  output logic                    result_valid_o,
  output ccrs_pkg::result_t       result_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);

  localparam int AddrW = ccrs_pkg::AddrW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDO  = 4'd1;
  localparam logic [3:0] S_RDK  = 4'd2;
  localparam logic [3:0] S_RDN  = 4'd3;
  localparam logic [3:0] S_GO   = 4'd4;
  localparam logic [3:0] S_WAIT = 4'd5;
  localparam logic [3:0] S_WRK  = 4'd6;
  localparam logic [3:0] S_WRN  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] st_q, st_d;
  logic [39:0] gain_q;
  logic [31:0] offset_q;
  logic [AddrW-1:0] k_q, next_k, idx_addr, rd_addr, wr_addr;
  logic odd_pass_q, in_range, in_range_q, accept, pass_end;
  logic [AddrW:0] k_plus2;

  // Site stores: one write and one registered read per cycle.
  logic [31:0] amp_mem [ccrs_pkg::SiteCount];
  logic [31:0] ph_mem  [ccrs_pkg::SiteCount];
  logic [31:0] amp_rd_q, ph_rd_q, amp_wd, a_q, ph_q;
  logic amp_we, ph_we;

  logic cordic_go, cordic_done;
  logic signed [31:0] rot_a, rot_b;
  logic [31:0] mapped;

  logic valid_q;
  ccrs_pkg::result_t res_q;

  // Configuration port; bit 3 of the address picks the register.
  assign pready = 1'b1;
  assign prdata = paddr[3] ? {32'd0, offset_q} : {24'd0, gain_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= ccrs_pkg::GainReset;
      offset_q <= ccrs_pkg::OffsetReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) offset_q <= pwdata[31:0];
      else gain_q <= pwdata[39:0];
    end
  end

  assign accept   = start && !busy;
  assign busy     = (st_q != S_IDLE);
  assign in_range = (int'(cmd_i.site_index) < ccrs_pkg::SiteCount);
  assign idx_addr = AddrW'(cmd_i.site_index);
  assign next_k   = (k_q == AddrW'(ccrs_pkg::SiteCount - 1)) ? '0 : k_q + 1'b1;
  assign k_plus2  = {1'b0, k_q} + (AddrW+1)'(2);
  assign pass_end = (k_plus2 >= (AddrW+1)'(ccrs_pkg::SiteCount));

  always_comb begin
    unique case (st_q)
      S_RDK:   rd_addr = k_q;
      S_RDN:   rd_addr = next_k;
      default: rd_addr = idx_addr;
    endcase
  end

  // Writes: a load in the accepting cycle, then both halves of a site step.
  always_comb begin
    amp_we = 1'b0;
    ph_we  = 1'b0;
    wr_addr = idx_addr;
    amp_wd = cmd_i.load_amplitude;
    unique case (st_q)
      S_IDLE: begin
        amp_we = accept && cmd_i.operation == ccrs_pkg::OpLoad && in_range;
        ph_we  = amp_we;
      end
      S_WRK: begin
        amp_we = 1'b1;
        ph_we  = 1'b1;
        wr_addr = k_q;
        amp_wd = rot_a;
      end
      S_WRN: begin
        amp_we = 1'b1;
        wr_addr = next_k;
        amp_wd = rot_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (amp_we) amp_mem[wr_addr] <= amp_wd;
    if (ph_we) ph_mem[wr_addr] <= (st_q == S_WRK) ? mapped : cmd_i.load_phase;
    amp_rd_q <= amp_mem[rd_addr];
    ph_rd_q  <= ph_mem[rd_addr];
    if (st_q == S_RDN) begin
      a_q  <= amp_rd_q;
      ph_q <= ph_rd_q;
    end
    if (accept) in_range_q <= in_range;
  end

  assign cordic_go = (st_q == S_GO);

  ccrs_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_go),
    .amp_a_i (a_q),
    .amp_b_i (amp_rd_q),
    .phase_i (ph_q),
    .done_o  (cordic_done),
    .rot_a_o (rot_a),
    .rot_b_o (rot_b)
  );

  // The phase map finishes long before the rotation.
  ccrs_map u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cordic_go),
    .phase_i  (ph_q),
    .gain_i   (gain_q),
    .offset_i (offset_q),
    .phase_o  (mapped)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.operation == ccrs_pkg::OpRead) st_d = S_RDO;
          else if (cmd_i.operation == ccrs_pkg::OpSweep) st_d = S_RDK;
        end
      end
      S_RDO:  st_d = S_IDLE;
      S_RDK:  st_d = S_RDN;
      S_RDN:  st_d = S_GO;
      S_GO:   st_d = S_WAIT;
      S_WAIT: if (cordic_done) st_d = S_WRK;
      S_WRK:  st_d = S_WRN;
      S_WRN:  st_d = (pass_end && odd_pass_q) ? S_DONE : S_RDK;
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      k_q        <= '0;
      odd_pass_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_q <= (st_q == S_RDO) || (st_q == S_DONE);
      if (st_q == S_IDLE) begin
        k_q        <= '0;
        odd_pass_q <= 1'b0;
      end else if (st_q == S_WRN) begin
        if (pass_end) begin
          // The odd pass starts at site one.
          k_q        <= AddrW'(1);
          odd_pass_q <= 1'b1;
        end else begin
          k_q <= k_plus2[AddrW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_RDO) begin
      res_q.result_kind   <= ccrs_pkg::KindRead;
      res_q.amplitude_out <= in_range_q ? amp_rd_q : '0;
      res_q.phase_out     <= in_range_q ? ph_rd_q : '0;
    end else if (st_q == S_DONE) begin
      res_q.result_kind   <= ccrs_pkg::KindSweep;
      res_q.amplitude_out <= '0;
      res_q.phase_out     <= '0;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_sweep_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.result_kind == ccrs_pkg::KindSweep)
      |-> $past(st_q) == S_DONE)
    else $error("sweep result without a finished sweep");

  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation == ccrs_pkg::OpSweep) |=> busy)
    else $error("sweep accepted but block not busy");

  a_write_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_WRK) |-> $past(cordic_done))
    else $error("site written before rotation finished");

endmodule

// ===== rtl/ccrs_map.sv =====
module ccrs_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] phase_i,
  input  logic [39:0] gain_i,
  input  logic [31:0] offset_i,
  output logic [31:0] phase_o
);

  logic [31:0] p_q;
  logic        s1_q, s2_q;
  logic [63:0] lo_prod_q;
  logic [31:0] res_q;
  logic [39:0] hi_prod;

  assign hi_prod = 40'(gain_i[39:32] * p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= start_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) p_q <= phase_i;
    if (s1_q) lo_prod_q <= 64'(gain_i[31:0]) * 64'(p_q);
    if (s2_q) res_q <= hi_prod[31:0] + lo_prod_q[63:32] + offset_i;
  end

  assign phase_o = res_q;

endmodule

// ===== rtl/ccrs_cordic.sv =====
module ccrs_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] amp_a_i,
  input  logic signed [31:0] amp_b_i,
  input  logic [31:0]        phase_i,
  output logic               done_o,
  output logic signed [31:0] rot_a_o,
  output logic signed [31:0] rot_b_o
);

  localparam int RotW = ccrs_pkg::RotW;
  localparam int AngW = ccrs_pkg::AngW;
  localparam int IterW = ccrs_pkg::IterW;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MULA = 3'd1;
  localparam logic [2:0] C_MULB = 3'd2;
  localparam logic [2:0] C_QUAD = 3'd3;
  localparam logic [2:0] C_ITER = 3'd4;
  localparam logic [2:0] C_FIN  = 3'd5;

  logic [2:0] st_q, st_d;
  logic [IterW-1:0] it_q;
  logic signed [31:0] a_q, b_q, mul_in;
  logic [31:0] ph_q;
  logic signed [RotW-1:0] x_q, y_q, dx, dy;
  logic signed [AngW-1:0] z_q, atan_ext;
  logic signed [65:0] prod, scaled;
  logic [1:0] quad;
  logic [31:0] resid;
  logic done_q;
  logic signed [31:0] ra_q, rb_q;

  function automatic logic signed [31:0] sat_round(input logic signed [RotW-1:0] w);
    logic signed [RotW:0] r;
    r = ($signed({w[RotW-1], w}) + (RotW+1)'(1 << (ccrs_pkg::GuardBits - 1)))
        >>> ccrs_pkg::GuardBits;
    if (r > (RotW+1)'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    else if (r < -(RotW+1)'(33'sh080000000)) return 32'sh80000000;
    else return r[31:0];
  endfunction

  assign mul_in = (st_q == C_MULA) ? a_q : b_q;
  assign prod = $signed(mul_in) * $signed({1'b0, ccrs_pkg::CordicGain});
  assign scaled = (prod + 66'sd8388608) >>> (32 - ccrs_pkg::GuardBits);

  assign quad = 2'(ph_q + 32'h20000000 >> 30);
  assign resid = ph_q - {quad, 30'd0};

  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign atan_ext = AngW'(ccrs_pkg::atan_turns(6'(it_q)));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      C_IDLE: if (start_i) st_d = C_MULA;
      C_MULA: st_d = C_MULB;
      C_MULB: st_d = C_QUAD;
      C_QUAD: st_d = C_ITER;
      C_ITER: if (it_q == IterW'(ccrs_pkg::IterCount - 1)) st_d = C_FIN;
      C_FIN:  st_d = C_IDLE;
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      it_q   <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == C_FIN);
      if (st_q == C_ITER) it_q <= it_q + 1'b1;
      else it_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      C_IDLE: begin
        if (start_i) begin
          a_q  <= amp_a_i;
          b_q  <= amp_b_i;
          ph_q <= phase_i;
        end
      end
      C_MULA: x_q <= scaled[RotW-1:0];
      C_MULB: y_q <= scaled[RotW-1:0];
      C_QUAD: begin
        // Whole quarter turns are applied exactly before the iterations.
        unique case (quad)
          2'd1: begin x_q <= -y_q; y_q <= x_q;  end
          2'd2: begin x_q <= -x_q; y_q <= -y_q; end
          2'd3: begin x_q <= y_q;  y_q <= -x_q; end
          default: ;
        endcase
        z_q <= AngW'($signed(resid));
      end
      C_ITER: begin
        if (!z_q[AngW-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_ext;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_ext;
        end
      end
      C_FIN: begin
        ra_q <= sat_round(x_q);
        rb_q <= sat_round(y_q);
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign rot_a_o = ra_q;
  assign rot_b_o = rb_q;

endmodule

// ===== sim/tb.sv =====
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // The run is bounded by a cycle budget. The budget covers every item after
  // the preload being a sweep, several times over.
  localparam int unsigned CycleLimit = 10_000_000;
  localparam int unsigned ItemsPerPhase = 34;

  // Register addresses. The gain register is 40 bits wide, so registers sit
  // on an 8-byte stride.
  localparam logic [3:0] GainAddr   = 4'd0;
  localparam logic [3:0] OffsetAddr = 4'd8;

  // The rotation angle table, in units of 2^-32 turn.
  localparam longint AngleStep [40] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  // The scoreboard keeps its own copy of the ring and of the phase map
  // settings. It queues the results that each accepted item should produce.
  class ring_scoreboard;
    logic [31:0]       amp_mem [ccrs_pkg::SiteCount];
    logic [31:0]       phase_mem [ccrs_pkg::SiteCount];
    logic [39:0]       gain;
    logic [31:0]       offset;
    ccrs_pkg::result_t pending_q [$];
    int                errors;

    function new();
      gain   = 40'd8589934592;
      offset = 32'd1028592847;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Rounding by the guard bits, then saturation to 32 bits.
    function logic [31:0] round_sat(input longint w);
      longint r;
      r = (w + 64'sd128) >>> 8;
      if (r >= -64'sd2147483648 && r <= 64'sd2147483647) return r[31:0];
      return (r < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function void rotate(input int a, input int b, input logic [31:0] ph);
      longint      x, y, t, z, dx, dy;
      logic [31:0] shifted, resid;
      logic [1:0]  quad;
      x = longint'($signed(amp_mem[a])) * longint'({32'd0, ccrs_pkg::CordicGain});
      y = longint'($signed(amp_mem[b])) * longint'({32'd0, ccrs_pkg::CordicGain});
      x = (x + 64'sh80_0000) >>> 24;
      y = (y + 64'sh80_0000) >>> 24;
      shifted = ph + 32'h2000_0000;
      quad = shifted[31:30];
      resid = ph - {quad, 30'd0};
      z = longint'($signed(resid));
      // Whole quarter turns are taken exactly before the fine rotation.
      case (quad)
        2'd1: begin t = x; x = -y; y = t; end
        2'd2: begin x = -x; y = -y; end
        2'd3: begin t = x; x = y; y = -t; end
        default: ;
      endcase
      for (int i = 0; i < ccrs_pkg::IterCount; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - AngleStep[i];
        end else begin
          x = x + dx; y = y - dy; z = z + AngleStep[i];
        end
      end
      amp_mem[a] = round_sat(x);
      amp_mem[b] = round_sat(y);
    endfunction

    function logic [31:0] next_phase(input logic [31:0] p);
      logic [63:0] hi, lo, pp, f;
      hi = {56'd0, gain[39:32]};
      lo = {32'd0, gain[31:0]};
      pp = {32'd0, p};
      f = hi * pp + ((lo * pp) >> 32);
      return f[31:0] + offset;
    endfunction

    function void step_site(input int k);
      rotate(k, (k + 1) % ccrs_pkg::SiteCount, phase_mem[k]);
      phase_mem[k] = next_phase(phase_mem[k]);
    endfunction

    function void note_item(input ccrs_pkg::cmd_t c);
      ccrs_pkg::result_t r;
      case (c.operation)
        ccrs_pkg::OpLoad: begin
          amp_mem[c.site_index]   = c.load_amplitude;
          phase_mem[c.site_index] = c.load_phase;
        end
        ccrs_pkg::OpSweep: begin
          for (int k = 0; k < ccrs_pkg::SiteCount; k += 2) step_site(k);
          for (int k = 1; k < ccrs_pkg::SiteCount; k += 2) step_site(k);
          r = '0;
          r.result_kind = ccrs_pkg::KindSweep;
          pending_q.push_back(r);
        end
        ccrs_pkg::OpRead: begin
          r.result_kind   = ccrs_pkg::KindRead;
          r.amplitude_out = amp_mem[c.site_index];
          r.phase_out     = phase_mem[c.site_index];
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task check_result(input ccrs_pkg::result_t got);
      ccrs_pkg::result_t want;
      if (pending_q.size() == 0) begin
        report("result with no item waiting for it");
        return;
      end
      want = pending_q.pop_front();
      if (got.result_kind !== want.result_kind)
        report($sformatf("kind %0b, expected %0b", got.result_kind, want.result_kind));
      if (got.amplitude_out !== want.amplitude_out)
        report($sformatf("amplitude %h, expected %h", got.amplitude_out, want.amplitude_out));
      if (got.phase_out !== want.phase_out)
        report($sformatf("phase %h, expected %h", got.phase_out, want.phase_out));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  ccrs_pkg::cmd_t    cmd_i;
  logic              result_valid_o;
  ccrs_pkg::result_t result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;

  ring_scoreboard sb;
  int unsigned    cycles = 0;
  bit             gaps_on;

  chaotic_rotation_chain_sweep uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The monitor samples at the rising edge, before the block's own updates
  // of that edge land. An item counts as taken when start is high and busy is
  // low. A result counts when its strobe is high, since it cannot be held off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start && !busy) sb.note_item(cmd_i);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes it. Afterwards the
  // sender sometimes leaves a short gap, so that gaps land on every phase of
  // the block's work.
  task send_item(input ccrs_pkg::cmd_t c);
    int gap;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (!(start && !busy));
    if (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task send_op(input logic [1:0] op, input int site, input logic [31:0] amp,
               input logic [31:0] ph);
    ccrs_pkg::cmd_t c;
    c.operation      = op;
    c.site_index     = site[8:0];
    c.load_amplitude = amp;
    c.load_phase     = ph;
    send_item(c);
  endtask

  // Waits until every expected result has come and the block is idle. A load
  // gives no result, so a few more cycles pass before anything else happens.
  task wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One APB write: a setup cycle, then an access cycle. The register takes
  // the value at the edge that ends the access cycle.
  task reg_write(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == GainAddr) sb.gain = data[39:0];
    else sb.offset = data[31:0];
  endtask

  task set_map(input logic [39:0] g, input logic [31:0] o);
    wait_drained();
    reg_write(GainAddr, {24'd0, g});
    reg_write(OffsetAddr, {32'd0, o});
    repeat (2) @(posedge clk_i);
  endtask

  // Random items. Sweeps are kept rare because each one is long. The ring
  // is fully loaded, so every read and every sweep stays within the contract.
  task random_items(input int count, input bit hold_off);
    int unsigned roll;
    for (int n = 0; n < count; n++) begin
      if (hold_off && n == count / 2) wait_drained();
      roll = $urandom_range(99);
      if (roll < 40)
        send_op(ccrs_pkg::OpLoad, $urandom_range(ccrs_pkg::SiteCount - 1), $urandom,
                $urandom);
      else if (roll < 85)
        send_op(ccrs_pkg::OpRead, $urandom_range(ccrs_pkg::SiteCount - 1), $urandom,
                $urandom);
      else if (roll < 92)
        send_op(ccrs_pkg::OpSweep, $urandom_range(ccrs_pkg::SiteCount - 1), $urandom,
                $urandom);
      else
        send_op(ccrs_pkg::OpUnused, $urandom_range(ccrs_pkg::SiteCount - 1), $urandom,
                $urandom);
    end
  endtask

  initial begin
    sb      = new();
    gaps_on = 1'b0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every site must hold data before it is read or swept, so the whole ring
    // is loaded first with random content.
    for (int s = 0; s < ccrs_pkg::SiteCount; s++)
      send_op(ccrs_pkg::OpLoad, s, $urandom, $urandom);
    gaps_on = 1'b1;

    // Directed items: amplitude extremes, phases on and near the quarter-turn
    // boundaries, the unused operation, and reads at both ends of the ring.
    send_op(ccrs_pkg::OpLoad, 0, 32'h8000_0000, 32'h0000_0000);
    send_op(ccrs_pkg::OpLoad, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(ccrs_pkg::OpLoad, 2, 32'h0000_0000, 32'h2000_0000);
    send_op(ccrs_pkg::OpLoad, 3, 32'h7FFF_FFFF, 32'h1FFF_FFFF);
    send_op(ccrs_pkg::OpLoad, 4, 32'h8000_0000, 32'h6000_0000);
    send_op(ccrs_pkg::OpLoad, 5, 32'hC000_0000, 32'hA000_0000);
    send_op(ccrs_pkg::OpLoad, 6, 32'h4000_0000, 32'hE000_0000);
    send_op(ccrs_pkg::OpLoad, 511, 32'h7FFF_FFFF, 32'h4000_0000);
    send_op(ccrs_pkg::OpRead, 0, '0, '0);
    send_op(ccrs_pkg::OpRead, 511, '1, '1);
    send_op(ccrs_pkg::OpUnused, 7, '1, '1);
    send_op(ccrs_pkg::OpSweep, 0, '0, '0);
    send_op(ccrs_pkg::OpRead, 0, '0, '0);
    send_op(ccrs_pkg::OpRead, 1, '0, '0);
    send_op(ccrs_pkg::OpRead, 4, '0, '0);
    send_op(ccrs_pkg::OpRead, 511, '0, '0);

    // Random phases under several map settings: the reset setting, the top
    // of both ranges, zero, and random values. The second phase runs without
    // any gaps and pauses once until everything expected has arrived.
    random_items(ItemsPerPhase, 1'b0);
    set_map(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
    gaps_on = 1'b0;
    random_items(ItemsPerPhase, 1'b1);
    gaps_on = 1'b1;
    set_map(40'd0, 32'd0);
    send_op(ccrs_pkg::OpSweep, 0, '0, '0);
    send_op(ccrs_pkg::OpRead, 100, '0, '0);
    set_map({8'($urandom_range(255)), $urandom}, $urandom);
    random_items(ItemsPerPhase, 1'b0);

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
